>>> hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// shared constants, types and the partition size table of the allocator
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int MaxJobsDefault  = 16;
	localparam int NumPartsDefault = 10;
	localparam int SizeW           = 14;
	localparam int TimeW           = 16;
	localparam int PartTimeW       = 17;
	localparam int StatusW         = 3;
	localparam int JobIdW          = 5;
	localparam int PartIdxW        = 4;
	localparam int DropW           = 5;
	localparam int SumW            = 18;
	localparam int CfgIdxW         = 1;
	localparam int CfgDataW        = 14;

	localparam logic [SizeW-1:0] MaxSizeReset = SizeW'(9500);

	typedef enum logic [StatusW-1:0] {
		ST_QUEUED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_PLACED  = 3'd2,
		ST_DROPPED = 3'd3,
		ST_NONE    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		POL_FIRST   = 2'd0,
		POL_BEST    = 2'd1,
		POL_REVERSE = 2'd2,
		POL_WORST   = 2'd3
	} policy_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_POLICY   = 1'd0,
		REG_MAX_SIZE = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		JS_EMPTY   = 2'd0,
		JS_PENDING = 2'd1,
		JS_PLACED  = 2'd2,
		JS_DROPPED = 2'd3
	} job_state_t;

	// search request and answer between sequencer and fit unit
	typedef struct packed {
		logic             start;
		logic [1:0]       policy;
		logic [SizeW-1:0] size;
	} fit_req_t;

	typedef struct packed {
		logic done;
		logic found;
	} fit_rsp_t;

	// table repeats every ten partitions; indexes stay below eighty
	function automatic logic [SizeW-1:0] part_size(input int unsigned p);
		int unsigned r;
		r = p;
		if (r >= 40) r = r - 40;
		if (r >= 20) r = r - 20;
		if (r >= 10) r = r - 10;
		case (r)
			0: part_size = SizeW'(9500);
			1: part_size = SizeW'(7000);
			2: part_size = SizeW'(4500);
			3: part_size = SizeW'(8500);
			4: part_size = SizeW'(3000);
			5: part_size = SizeW'(9000);
			6: part_size = SizeW'(1000);
			7: part_size = SizeW'(5500);
			8: part_size = SizeW'(1500);
			default: part_size = SizeW'(500);
		endcase
	endfunction

endpackage

>>> hw/rtl/fpa_fit_unit.sv
// ----------------------------------------------------------------------------
// fpa_fit_unit
// walks the partitions one a cycle and keeps the chosen one by policy
// ----------------------------------------------------------------------------
module fpa_fit_unit #(
	parameter int NUM_PARTITIONS = fpa_pkg::NumPartsDefault,
	parameter int PW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fpa_pkg::fit_req_t            req,
	input  logic [NUM_PARTITIONS-1:0]    busy,
	output fpa_pkg::fit_rsp_t            rsp,
	output logic [PW-1:0]                best
);
	logic                       run_q;
	logic [PW-1:0]              cnt_q;
	logic                       found_q;
	logic [PW-1:0]              best_q;
	logic [fpa_pkg::SizeW-1:0]  best_size_q;
	logic [PW-1:0]              q_idx;
	logic [fpa_pkg::SizeW-1:0]  q_size;
	logic                       fits;
	logic                       take;
	logic                       last;
	logic                       first_kind;

	assign q_idx = (req.policy == fpa_pkg::POL_REVERSE) ?
		PW'(NUM_PARTITIONS - 1) - cnt_q : cnt_q;
	assign q_size = fpa_pkg::part_size(32'(q_idx));
	assign fits = !busy[q_idx] && (q_size >= req.size);
	assign first_kind = (req.policy == fpa_pkg::POL_FIRST) ||
		(req.policy == fpa_pkg::POL_REVERSE);
	always_comb begin
		take = 1'b0;
		if (fits) begin
			if (!found_q) take = 1'b1;
			else if (req.policy == fpa_pkg::POL_BEST) take = q_size < best_size_q;
			else if (req.policy == fpa_pkg::POL_WORST) take = q_size > best_size_q;
		end
	end
	assign last = (cnt_q == PW'(NUM_PARTITIONS - 1)) || (first_kind && fits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			rsp     <= '0;
		end else begin
			rsp.done <= run_q && !req.start && last;
			if (req.start) begin
				run_q   <= 1'b1;
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else if (run_q) begin
				if (take) found_q <= 1'b1;
				cnt_q <= cnt_q + PW'(1);
				if (last) begin
					run_q     <= 1'b0;
					rsp.found <= found_q || take;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q && take) begin
			best_q      <= q_idx;
			best_size_q <= q_size;
		end
	end
	assign best = best_q;
endmodule

>>> hw/rtl/fixed_partition_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_allocator
// job queue and fixed partition placement with four fit policies
// ----------------------------------------------------------------------------
// sequence: an enqueue goes straight to the result word; a tick first counts
//   down every partition, then passes over finished jobs and tries each pending
//   job in the fit unit until one is placed or dropped or none is left
// throughput: one word at a time, busy high until the result strobe
// the shared fit unit scans one partition a cycle; the result strobe is one
// cycle wide and the receiver cannot stall; reset clears control state and config, not the job payload memory
module fixed_partition_allocator #(
	parameter int MAX_JOBS       = fpa_pkg::MaxJobsDefault,
	parameter int NUM_PARTITIONS = fpa_pkg::NumPartsDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           opcode,
	input  logic [fpa_pkg::SizeW-1:0]      job_size,
	input  logic [fpa_pkg::TimeW-1:0]      run_time,
	input  logic                           cfg_we,
	input  logic [fpa_pkg::CfgIdxW-1:0]    cfg_idx,
	input  logic [fpa_pkg::CfgDataW-1:0]   cfg_data,
	output logic                           done,
	output logic [fpa_pkg::StatusW-1:0]    status,
	output logic [fpa_pkg::JobIdW-1:0]     job_id,
	output logic [fpa_pkg::PartIdxW-1:0]   partition_index,
	output logic                           work_left,
	output logic [fpa_pkg::DropW-1:0]      dropped_total,
	output logic [fpa_pkg::SumW-1:0]       placed_size_total
);
	localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int PW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DEC   = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_READ  = 7'b0001000,
		S_FIT   = 7'b0010000,
		S_WAIT  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0]                 policy_q;
	logic [fpa_pkg::SizeW-1:0]  max_size_q;

	// job store: pending bit per job in flops, payload in memory
	logic [MAX_JOBS-1:0]        pend_q;
	logic [CW-1:0]              count_q;
	logic [fpa_pkg::SizeW-1:0]  size_mem [MAX_JOBS];
	logic [fpa_pkg::TimeW-1:0]  time_mem [MAX_JOBS];
	logic [fpa_pkg::SizeW-1:0]  rd_size_q;
	logic [fpa_pkg::TimeW-1:0]  rd_time_q;

	// partitions
	logic [NUM_PARTITIONS-1:0]  pbusy_q;
	logic [fpa_pkg::PartTimeW-1:0] ptime_q [NUM_PARTITIONS];
	logic [PW-1:0]              pcnt_q;

	// scan of pending jobs
	logic [CW-1:0]              jcnt_q;
	logic [JW-1:0]              jidx;

	logic [fpa_pkg::DropW-1:0]  drop_q;
	logic [fpa_pkg::SumW-1:0]   sum_q;

	fpa_pkg::fit_req_t          fit_req;
	fpa_pkg::fit_rsp_t          fit_rsp;
	logic [PW-1:0]              fit_best;

	logic [fpa_pkg::StatusW-1:0] res_status_q;
	logic [fpa_pkg::JobIdW-1:0]  res_id_q;
	logic [fpa_pkg::PartIdxW-1:0] res_pidx_q;

	assign jidx = jcnt_q[JW-1:0];

	assign fit_req.start  = (state_q == S_FIT);
	assign fit_req.policy = policy_q;
	assign fit_req.size   = rd_size_q;

	fpa_fit_unit #(
		.NUM_PARTITIONS(NUM_PARTITIONS),
		.PW            (PW)
	) u_fit (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (fit_req),
		.busy  (pbusy_q),
		.rsp   (fit_rsp),
		.best  (fit_best)
	);

	assign busy = (state_q != S_IDLE);

	// config writes, only while idle: the user must keep to this, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= fpa_pkg::POL_FIRST;
			max_size_q <= fpa_pkg::MaxSizeReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fpa_pkg::REG_POLICY:   policy_q   <= cfg_data[1:0];
				fpa_pkg::REG_MAX_SIZE: max_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// job payload memory, written on enqueue, read one entry a cycle
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && !opcode && count_q < CW'(MAX_JOBS)) begin
			size_mem[count_q[JW-1:0]] <= job_size;
			time_mem[count_q[JW-1:0]] <= run_time;
		end
		rd_size_q <= size_mem[jidx];
		rd_time_q <= time_mem[jidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pend_q       <= '0;
			count_q      <= '0;
			pbusy_q      <= '0;
			pcnt_q       <= '0;
			jcnt_q       <= '0;
			drop_q       <= '0;
			sum_q        <= '0;
			res_status_q <= fpa_pkg::ST_NONE;
			res_id_q     <= '0;
			res_pidx_q   <= '0;
			for (int i = 0; i < NUM_PARTITIONS; i++) begin
				ptime_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						res_pidx_q <= '0;
						if (!opcode) begin
							if (count_q < CW'(MAX_JOBS)) begin
								pend_q[count_q[JW-1:0]] <= 1'b1;
								count_q      <= count_q + CW'(1);
								res_status_q <= fpa_pkg::ST_QUEUED;
								res_id_q     <= fpa_pkg::JobIdW'(count_q + CW'(1));
							end else begin
								res_status_q <= fpa_pkg::ST_FULL;
								res_id_q     <= '0;
							end
							state_q <= S_OUT;
						end else begin
							// nothing placed unless the scan finds a job
							res_status_q <= fpa_pkg::ST_NONE;
							res_id_q     <= '0;
							pcnt_q       <= '0;
							state_q      <= S_DEC;
						end
					end
				end
				// count each busy partition down, one a cycle
				S_DEC: begin
					if (pbusy_q[pcnt_q]) begin
						if (ptime_q[pcnt_q] <= fpa_pkg::PartTimeW'(1)) begin
							ptime_q[pcnt_q] <= '0;
							pbusy_q[pcnt_q] <= 1'b0;
						end else begin
							ptime_q[pcnt_q] <= ptime_q[pcnt_q] - fpa_pkg::PartTimeW'(1);
						end
					end
					pcnt_q <= pcnt_q + PW'(1);
					if (pcnt_q == PW'(NUM_PARTITIONS - 1)) begin
						jcnt_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				// find next pending job
				S_SCAN: begin
					if (jcnt_q >= count_q) begin
						state_q <= S_OUT;
					end else if (pend_q[jidx]) begin
						state_q <= S_READ;
					end else begin
						jcnt_q <= jcnt_q + CW'(1);
					end
				end
				S_READ: begin
					if (rd_size_q > max_size_q) begin
						pend_q[jidx] <= 1'b0;
						drop_q       <= drop_q + fpa_pkg::DropW'(1);
						res_status_q <= fpa_pkg::ST_DROPPED;
						res_id_q     <= fpa_pkg::JobIdW'(jcnt_q + CW'(1));
						state_q      <= S_OUT;
					end else begin
						state_q <= S_FIT;
					end
				end
				S_FIT: state_q <= S_WAIT;
				S_WAIT: begin
					if (fit_rsp.done) begin
						if (fit_rsp.found) begin
							pend_q[jidx]      <= 1'b0;
							pbusy_q[fit_best] <= 1'b1;
							ptime_q[fit_best] <= fpa_pkg::PartTimeW'(rd_time_q);
							sum_q             <= sum_q + fpa_pkg::SumW'(rd_size_q);
							res_status_q      <= fpa_pkg::ST_PLACED;
							res_id_q          <= fpa_pkg::JobIdW'(jcnt_q + CW'(1));
							res_pidx_q        <= fpa_pkg::PartIdxW'(fit_best);
							state_q           <= S_OUT;
						end else begin
							jcnt_q  <= jcnt_q + CW'(1);
							state_q <= S_SCAN;
						end
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word, one cycle wide
	assign done              = (state_q == S_OUT);
	assign status            = res_status_q;
	assign job_id            = res_id_q;
	assign partition_index   = res_pidx_q;
	assign work_left         = (|pend_q) || (|pbusy_q);
	assign dropped_total     = drop_q;
	assign placed_size_total = sum_q;
endmodule

>>> hw/rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// port level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
module fpa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [fpa_pkg::StatusW-1:0]   status,
	input logic [fpa_pkg::JobIdW-1:0]    job_id,
	input logic [fpa_pkg::PartIdxW-1:0]  partition_index,
	input logic [fpa_pkg::DropW-1:0]     dropped_total
);
	// a word ends the busy period
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");

	// accepted command makes busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after start");

	// placement index only with placed status
	a_pidx: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != fpa_pkg::ST_PLACED) |-> partition_index == '0)
		else $error("stray partition index");

	// no job number when the queue refuses or nothing is placed
	a_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == fpa_pkg::ST_FULL || status == fpa_pkg::ST_NONE))
		|-> job_id == '0)
		else $error("stray job number");

	// drop count moves only with a drop word
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != fpa_pkg::ST_DROPPED) |-> $stable(dropped_total))
		else $error("drop count moved");
endmodule

bind fixed_partition_allocator fpa_checker u_fpa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .job_id(job_id), .partition_index(partition_index),
	.dropped_total(dropped_total)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fixed partition allocator: directed fit-policy
// tests, then random words over changing settings, each result checked
// against an in-bench model of the job queue and the partitions
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NJOBS  = fpa_pkg::MaxJobsDefault;
	localparam int NPARTS = fpa_pkg::NumPartsDefault;

	// expected fields of one result word
	typedef struct {
		fpa_pkg::status_t                 status;
		logic [fpa_pkg::JobIdW-1:0]       job_id;
		logic [fpa_pkg::PartIdxW-1:0]     part;
		logic                             work;
		logic [fpa_pkg::DropW-1:0]        drops;
		logic [fpa_pkg::SumW-1:0]         sum;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = 1'b0;
	logic [fpa_pkg::SizeW-1:0] job_size = '0;
	logic [fpa_pkg::TimeW-1:0] run_time = '0;
	logic cfg_we = 1'b0;
	logic [fpa_pkg::CfgIdxW-1:0] cfg_idx = '0;
	logic [fpa_pkg::CfgDataW-1:0] cfg_data = '0;
	logic done;
	logic [fpa_pkg::StatusW-1:0] status;
	logic [fpa_pkg::JobIdW-1:0] job_id;
	logic [fpa_pkg::PartIdxW-1:0] partition_index;
	logic work_left;
	logic [fpa_pkg::DropW-1:0] dropped_total;
	logic [fpa_pkg::SumW-1:0] placed_size_total;

	// model state: queue of jobs and the partitions
	fpa_pkg::policy_t          cur_policy;
	logic [fpa_pkg::SizeW-1:0] cur_max_size;
	logic [fpa_pkg::SizeW-1:0] q_size [NJOBS];
	logic [fpa_pkg::TimeW-1:0] q_time [NJOBS];
	fpa_pkg::job_state_t       q_state [NJOBS];
	int                        q_count;
	logic                      p_busy [NPARTS];
	int                        p_left [NPARTS];
	logic [fpa_pkg::DropW-1:0] drop_cnt;
	logic [fpa_pkg::SumW-1:0]  size_sum;

	alloc_result_t pending_results[$];
	int errors = 0;

	fixed_partition_allocator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .job_size(job_size), .run_time(run_time),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.done(done), .status(status), .job_id(job_id),
		.partition_index(partition_index), .work_left(work_left),
		.dropped_total(dropped_total), .placed_size_total(placed_size_total)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("fixed_partition_allocator verification failed");
		$finish;
	end

	// partition chosen for a job size, NPARTS when none fits
	function automatic int pick_partition(input logic [fpa_pkg::SizeW-1:0] sz);
		int best;
		int q;
		best = NPARTS;
		for (int p = 0; p < NPARTS; p++) begin
			q = (cur_policy == fpa_pkg::POL_REVERSE) ? NPARTS - 1 - p : p;
			if (p_busy[q] || fpa_pkg::part_size(q) < sz)
				continue;
			if (cur_policy == fpa_pkg::POL_FIRST || cur_policy == fpa_pkg::POL_REVERSE)
				return q;
			if (best == NPARTS)
				best = q;
			else if (cur_policy == fpa_pkg::POL_BEST &&
					fpa_pkg::part_size(q) < fpa_pkg::part_size(best))
				best = q;
			else if (cur_policy == fpa_pkg::POL_WORST &&
					fpa_pkg::part_size(q) > fpa_pkg::part_size(best))
				best = q;
		end
		return best;
	endfunction

	// advance the model by one word and return what the block should answer
	function automatic alloc_result_t model_word(input logic op,
			input logic [fpa_pkg::SizeW-1:0] sz, input logic [fpa_pkg::TimeW-1:0] rt);
		alloc_result_t r;
		int p;
		r.status = fpa_pkg::ST_NONE;
		r.job_id = '0;
		r.part = '0;
		if (op == 1'b0) begin
			if (q_count < NJOBS) begin
				q_size[q_count] = sz;
				q_time[q_count] = rt;
				q_state[q_count] = fpa_pkg::JS_PENDING;
				q_count++;
				r.status = fpa_pkg::ST_QUEUED;
				r.job_id = fpa_pkg::JobIdW'(q_count);
			end else begin
				r.status = fpa_pkg::ST_FULL;
			end
		end else begin
			// count down busy partitions, free at one or zero
			for (int i = 0; i < NPARTS; i++)
				if (p_busy[i]) begin
					if (p_left[i] <= 1) begin
						p_left[i] = 0;
						p_busy[i] = 1'b0;
					end else begin
						p_left[i]--;
					end
				end
			for (int i = 0; i < q_count; i++) begin
				if (q_state[i] != fpa_pkg::JS_PENDING)
					continue;
				if (q_size[i] > cur_max_size) begin
					q_state[i] = fpa_pkg::JS_DROPPED;
					drop_cnt++;
					r.status = fpa_pkg::ST_DROPPED;
					r.job_id = fpa_pkg::JobIdW'(i + 1);
					break;
				end
				p = pick_partition(q_size[i]);
				if (p < NPARTS) begin
					q_state[i] = fpa_pkg::JS_PLACED;
					p_busy[p] = 1'b1;
					p_left[p] = q_time[i];
					size_sum = size_sum + fpa_pkg::SumW'(q_size[i]);
					r.status = fpa_pkg::ST_PLACED;
					r.job_id = fpa_pkg::JobIdW'(i + 1);
					r.part = fpa_pkg::PartIdxW'(p);
					break;
				end
			end
		end
		r.work = 1'b0;
		for (int i = 0; i < q_count; i++)
			if (q_state[i] == fpa_pkg::JS_PENDING)
				r.work = 1'b1;
		for (int i = 0; i < NPARTS; i++)
			if (p_busy[i])
				r.work = 1'b1;
		r.drops = drop_cnt;
		r.sum = size_sum;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker: the strobe is one cycle, compare with oldest expectation
	always @(posedge clk) begin
		alloc_result_t w;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", status, -1);
			end else begin
				w = pending_results.pop_front();
				if (status !== w.status) report_mismatch("status", status, w.status);
				if (job_id !== w.job_id) report_mismatch("job_id", job_id, w.job_id);
				if (partition_index !== w.part)
					report_mismatch("partition_index", partition_index, w.part);
				if (work_left !== w.work) report_mismatch("work_left", work_left, w.work);
				if (dropped_total !== w.drops)
					report_mismatch("dropped_total", dropped_total, w.drops);
				if (placed_size_total !== w.sum)
					report_mismatch("placed_size_total", placed_size_total, w.sum);
			end
		end
	end

	// send one command word; start stays high on return so that a
	// back-to-back word needs no second assignment in the same step
	task automatic send_word(input logic op, input logic [fpa_pkg::SizeW-1:0] sz,
			input logic [fpa_pkg::TimeW-1:0] rt);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		job_size <= sz;
		run_time <= rt;
		forever begin
			@(negedge clk);
			if (!busy) begin
				@(posedge clk);
				break;
			end
		end
		pending_results.push_back(model_word(op, sz, rt));
	endtask

	// lower start and wait for every outstanding word
	task automatic drain_words;
		int waited;
		waited = 0;
		start <= 1'b0;
		while (pending_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$display("fixed_partition_allocator verification failed");
			$finish;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input fpa_pkg::cfg_reg_t idx,
			input logic [fpa_pkg::CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == fpa_pkg::REG_POLICY)
			cur_policy = fpa_pkg::policy_t'(val[1:0]);
		else
			cur_max_size = val;
	endtask

	task automatic ticks(input int n);
		for (int i = 0; i < n; i++)
			send_word(1'b1, fpa_pkg::SizeW'($urandom), fpa_pkg::TimeW'($urandom));
	endtask

	// default settings: exact fit, oversize drop, zero run time
	task automatic test_first_fit;
		send_word(1'b0, 14'd0, 16'd0);
		send_word(1'b0, 14'd9500, 16'd3);
		send_word(1'b0, 14'd9501, 16'd1);
		send_word(1'b0, 14'd4000, 16'd2);
		ticks(5);
		drain_words();
	endtask

	task automatic test_best_fit;
		write_reg(fpa_pkg::REG_POLICY, fpa_pkg::CfgDataW'(fpa_pkg::POL_BEST));
		send_word(1'b0, 14'd600, 16'd5);
		send_word(1'b0, 14'd3000, 16'd1);
		send_word(1'b0, 14'd4600, 16'd2);
		ticks(4);
		drain_words();
	endtask

	task automatic test_reverse_scan;
		write_reg(fpa_pkg::REG_POLICY, fpa_pkg::CfgDataW'(fpa_pkg::POL_REVERSE));
		send_word(1'b0, 14'd400, 16'd1);
		send_word(1'b0, 14'd7000, 16'd2);
		ticks(3);
		drain_words();
	endtask

	// largest size never fits, so later jobs go round it
	task automatic test_worst_fit;
		write_reg(fpa_pkg::REG_POLICY, fpa_pkg::CfgDataW'(fpa_pkg::POL_WORST));
		write_reg(fpa_pkg::REG_MAX_SIZE, 14'h3fff);
		send_word(1'b0, 14'h3fff, 16'd4);
		send_word(1'b0, 14'd100, 16'd1);
		send_word(1'b0, 14'd8600, 16'hffff);
		ticks(3);
		drain_words();
	endtask

	// zero limit drops the stuck job, size zero still fits
	task automatic test_zero_limit;
		write_reg(fpa_pkg::REG_POLICY, fpa_pkg::CfgDataW'(fpa_pkg::POL_FIRST));
		write_reg(fpa_pkg::REG_MAX_SIZE, 14'd0);
		ticks(1);
		send_word(1'b0, 14'd0, 16'd1);
		ticks(2);
		drain_words();
	endtask

	// random words over several settings; queue fills and then refuses
	task automatic test_random;
		logic [fpa_pkg::TimeW-1:0] rt;
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(fpa_pkg::REG_POLICY,
				fpa_pkg::CfgDataW'(ph == 9 ? 3 : $urandom_range(0, 3)));
			write_reg(fpa_pkg::REG_MAX_SIZE, ph == 0 ? 14'd0 : ph == 9 ? 14'h3fff :
				fpa_pkg::CfgDataW'($urandom));
			for (int i = 0; i < 55; i++) begin
				rt = ($urandom_range(0, 7) == 0) ? fpa_pkg::TimeW'($urandom) :
					fpa_pkg::TimeW'($urandom_range(0, 8));
				if ($urandom_range(0, 9) < 7)
					send_word(1'b1, fpa_pkg::SizeW'($urandom), fpa_pkg::TimeW'($urandom));
				else
					send_word(1'b0, fpa_pkg::SizeW'($urandom), rt);
			end
			drain_words();
		end
	endtask

	initial begin
		cur_policy = fpa_pkg::POL_FIRST;
		cur_max_size = fpa_pkg::MaxSizeReset;
		q_count = 0;
		drop_cnt = '0;
		size_sum = '0;
		for (int i = 0; i < NJOBS; i++)
			q_state[i] = fpa_pkg::JS_EMPTY;
		for (int i = 0; i < NPARTS; i++) begin
			p_busy[i] = 1'b0;
			p_left[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_first_fit();
		test_best_fit();
		test_reverse_scan();
		test_worst_fit();
		test_zero_limit();
		test_random();

		if (errors == 0)
			$display("fixed_partition_allocator verification clean");
		else
			$display("fixed_partition_allocator verification failed");
		$finish;
	end

endmodule

>>> fixed_partition_allocator.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_fit_unit.sv
hw/rtl/fixed_partition_allocator.sv
hw/rtl/fpa_checker.sv
dv/tb_top.sv
